// ===== hw/rtl/gts_pkg.sv =====
// types and constants shared by the grammar token scanner modules
`timescale 1ns / 1ps

package gts_pkg;

    // scanner mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DASH  = 2'd1,
        MODE_STR   = 2'd2,
        MODE_IDENT = 2'd3
    } mode_t;

    // token kinds
    typedef enum logic [3:0] {
        KIND_ARROW  = 4'd0,
        KIND_LPAREN = 4'd1,
        KIND_RPAREN = 4'd2,
        KIND_STAR   = 4'd3,
        KIND_OPT    = 4'd4,
        KIND_BAR    = 4'd5,
        KIND_SEMI   = 4'd6,
        KIND_LIT    = 4'd7,
        KIND_IDENT  = 4'd8,
        KIND_EOF    = 4'd9,
        KIND_ERR    = 4'd10
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_UNEXPECTED = 2'd1,
        ERR_OPEN_STR   = 2'd2
    } err_t;

    // source characters
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // most tokens one byte can cause
    localparam int unsigned MAX_TOKENS = 3;
    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] length;
        err_t        err;
    } token_t;

    // all tokens of one source byte, count is 1 to 3
    typedef struct packed {
        logic [1:0]                    count;
        token_t [MAX_TOKENS-1:0]       tok;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } push_t;

endpackage

// ===== hw/rtl/grammar_token_scanner.sv =====
// Grammar token scanner: streaming lexer of a small grammar notation.
// Input channel s_*: one source byte per request (s_ch), with s_end_of_source
// set on the final byte. Output channel m_*: one token per request with kind,
// line, start and length of literal or identifier text, error code, and
// m_last_result on the final token caused by a byte.
// cfg_we/cfg_wdata write first_line, the line number of the first line; it
// is loaded at the next source start, or at once if no byte has been taken.
// Throughput: one byte per cycle while the queue is not full; a byte that
// causes several tokens hands them out on m_* one request at a time. Bytes
// that cause no token (blanks, newlines, string and identifier bodies) never
// touch the output. The tokens of a byte reach m_* through a four-entry
// bundle queue and the bundle register of the output stage.
// Reset: scanner idle at position 0, line 1, first_line 1, queue empty.
// When the receiver stalls, the queue fills and s_ready drops once it holds
// four bundles; s_ready rises again the cycle after one leaves.
`timescale 1ns / 1ps

module grammar_token_scanner #(
    parameter int unsigned SOURCE_DEPTH = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [15:0] m_line,
    output logic [15:0] m_start_res,
    output logic [15:0] m_length,
    output logic [1:0]  m_error_code,
    output logic        m_last_result
);

    gts_pkg::push_t   push;
    gts_pkg::bundle_t q_data;
    logic             q_not_full;
    logic             q_valid;
    logic             q_pop;

    // byte scanner
    gts_front #(
        .SOURCE_DEPTH (SOURCE_DEPTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_end_of_source (s_end_of_source),
        .q_not_full      (q_not_full),
        .push            (push)
    );

    // bundle queue
    gts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .q_not_full (q_not_full),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop)
    );

    // token output
    gts_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_line        (m_line),
        .m_start_res   (m_start_res),
        .m_length      (m_length),
        .m_error_code  (m_error_code),
        .m_last_result (m_last_result)
    );

endmodule

// ===== hw/rtl/gts_front.sv =====
// front part: byte scanner state and token classification
`timescale 1ns / 1ps

module gts_front #(
    parameter int unsigned SOURCE_DEPTH = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_ch,
    input  logic             s_end_of_source,
    input  logic             q_not_full,
    output gts_pkg::push_t   push
);

    localparam int unsigned POS_MAX_INT =
        (SOURCE_DEPTH - 1 < 65535) ? SOURCE_DEPTH - 1 : 65535;
    localparam logic [15:0] POS_MAX = 16'(POS_MAX_INT);

    gts_pkg::mode_t mode_reg, mode_next, mode_mid;
    logic [15:0]    line_reg, line_next, line_mid;
    logic [15:0]    pos_reg, pos_next;
    logic [15:0]    ts_reg, ts_next, ts_mid;
    logic [15:0]    first_line_reg;

    logic           accept;
    logic           do_fresh;
    logic           is_alpha, is_alnum;
    logic [16:0]    ts_p1, lit_len_w, id_len_w;
    logic [15:0]    lit_start, lit_len, id_len;
    gts_pkg::token_t cand [4];
    logic [3:0]      cand_v;
    logic [1:0]      n_tok;
    gts_pkg::token_t slot [gts_pkg::MAX_TOKENS];

    function automatic gts_pkg::token_t mk_tok(gts_pkg::kind_t k, logic [15:0] ln,
                                               logic [15:0] st, logic [15:0] len,
                                               gts_pkg::err_t e);
        gts_pkg::token_t t;
        t.kind   = k;
        t.line   = ln;
        t.start  = st;
        t.length = len;
        t.err    = e;
        return t;
    endfunction

    assign s_ready = q_not_full;
    assign accept  = s_valid & s_ready;

    // character classes
    assign is_alpha = ((s_ch >= 8'h61) && (s_ch <= 8'h7A)) ||
                      ((s_ch >= 8'h41) && (s_ch <= 8'h5A));
    assign is_alnum = is_alpha || ((s_ch >= 8'h30) && (s_ch <= 8'h39));

    // literal and identifier extents
    assign ts_p1     = {1'b0, ts_reg} + 17'd1;
    assign lit_start = ts_p1[16] ? 16'hFFFF : ts_p1[15:0];
    assign lit_len_w = {1'b0, pos_reg} - ts_p1;
    assign lit_len   = ({1'b0, pos_reg} > ts_p1) ? lit_len_w[15:0] : 16'd0;
    assign id_len_w  = {1'b0, pos_reg} + 17'd1 - {1'b0, ts_mid};
    assign id_len    = id_len_w[16] ? 16'hFFFF : id_len_w[15:0];

    // scan one byte: mode step, fresh scan, end of source
    always_comb begin
        mode_mid  = mode_reg;
        ts_mid    = ts_reg;
        line_mid  = line_reg;
        do_fresh  = 1'b0;
        cand_v    = '0;
        for (int i = 0; i < 4; i++) begin
            cand[i] = mk_tok(gts_pkg::KIND_EOF, line_reg, 16'd0, 16'd0, gts_pkg::ERR_NONE);
        end

        unique case (mode_reg)
            gts_pkg::MODE_DASH: begin
                mode_mid = gts_pkg::MODE_IDLE;
                if (s_ch == gts_pkg::CH_GT) begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(gts_pkg::KIND_ARROW, line_reg, 16'd0, 16'd0,
                                       gts_pkg::ERR_NONE);
                end else begin
                    do_fresh = 1'b1;
                end
            end
            gts_pkg::MODE_STR: begin
                if (s_ch == gts_pkg::CH_QUOTE) begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(gts_pkg::KIND_LIT, line_reg, lit_start, lit_len,
                                       gts_pkg::ERR_NONE);
                    mode_mid  = gts_pkg::MODE_IDLE;
                end else if (s_ch == gts_pkg::CH_LF) begin
                    line_mid = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
                end
            end
            gts_pkg::MODE_IDENT: begin
                if (!is_alnum) begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk_tok(gts_pkg::KIND_IDENT, line_reg, ts_reg,
                                       pos_reg - ts_reg, gts_pkg::ERR_NONE);
                    mode_mid  = gts_pkg::MODE_IDLE;
                    do_fresh  = 1'b1;
                end
            end
            gts_pkg::MODE_IDLE: begin
                do_fresh = 1'b1;
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        // fresh byte decode
        if (do_fresh) begin
            cand[1] = mk_tok(gts_pkg::KIND_ERR, line_reg, 16'd0, 16'd0, gts_pkg::ERR_NONE);
            unique case (s_ch) inside
                gts_pkg::CH_DASH:   mode_mid = gts_pkg::MODE_DASH;
                gts_pkg::CH_LPAREN: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = gts_pkg::KIND_LPAREN;
                end
                gts_pkg::CH_RPAREN: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = gts_pkg::KIND_RPAREN;
                end
                gts_pkg::CH_STAR: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = gts_pkg::KIND_STAR;
                end
                gts_pkg::CH_QMARK: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = gts_pkg::KIND_OPT;
                end
                gts_pkg::CH_BAR: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = gts_pkg::KIND_BAR;
                end
                gts_pkg::CH_SEMI: begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = gts_pkg::KIND_SEMI;
                end
                gts_pkg::CH_LF: begin
                    line_mid = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
                end
                gts_pkg::CH_CR, gts_pkg::CH_SPACE, gts_pkg::CH_TAB: begin
                end
                gts_pkg::CH_QUOTE: begin
                    ts_mid   = pos_reg;
                    mode_mid = gts_pkg::MODE_STR;
                end
                default: begin
                    if (is_alpha) begin
                        ts_mid   = pos_reg;
                        mode_mid = gts_pkg::MODE_IDENT;
                    end else begin
                        cand_v[1]   = 1'b1;
                        cand[1].err = gts_pkg::ERR_UNEXPECTED;
                    end
                end
            endcase
        end

        // end of source closes any open token and adds eof
        if (s_end_of_source) begin
            if (mode_mid == gts_pkg::MODE_STR) begin
                cand_v[2] = 1'b1;
                cand[2]   = mk_tok(gts_pkg::KIND_ERR, line_mid, 16'd0, 16'd0,
                                   gts_pkg::ERR_OPEN_STR);
            end else if (mode_mid == gts_pkg::MODE_IDENT) begin
                cand_v[2] = 1'b1;
                cand[2]   = mk_tok(gts_pkg::KIND_IDENT, line_mid, ts_mid, id_len,
                                   gts_pkg::ERR_NONE);
            end
            cand_v[3] = 1'b1;
            cand[3]   = mk_tok(gts_pkg::KIND_EOF, line_mid, 16'd0, 16'd0, gts_pkg::ERR_NONE);
        end
    end

    // pack the valid tokens in order
    always_comb begin
        n_tok = 2'd0;
        for (int j = 0; j < gts_pkg::MAX_TOKENS; j++) begin
            slot[j] = cand[3];
        end
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (n_tok != 2'd3)) begin
                slot[n_tok] = cand[i];
                n_tok       = n_tok + 2'd1;
            end
        end
        push.valid         = accept && (n_tok != 2'd0);
        push.bundle.count  = n_tok;
        for (int j = 0; j < gts_pkg::MAX_TOKENS; j++) begin
            push.bundle.tok[j] = slot[j];
        end
    end

    // next scanner state
    always_comb begin
        if (s_end_of_source) begin
            mode_next = gts_pkg::MODE_IDLE;
            line_next = first_line_reg;
            pos_next  = 16'd0;
            ts_next   = 16'd0;
        end else begin
            mode_next = mode_mid;
            line_next = line_mid;
            ts_next   = ts_mid;
            pos_next  = (pos_reg < POS_MAX) ? pos_reg + 16'd1 : pos_reg;
        end
    end

    // state registers and first_line write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= gts_pkg::MODE_IDLE;
            line_reg       <= 16'd1;
            pos_reg        <= 16'd0;
            ts_reg         <= 16'd0;
            first_line_reg <= 16'd1;
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                ts_reg   <= ts_next;
            end
            // a write before the first byte of a source also loads the line count
            if (cfg_we && (pos_reg == 16'd0) && (mode_reg == gts_pkg::MODE_IDLE)) begin
                line_reg <= cfg_wdata;
            end else if (accept) begin
                line_reg <= line_next;
            end
            if (cfg_we) begin
                first_line_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== hw/rtl/gts_queue.sv =====
// short queue of token bundles between front and back
`timescale 1ns / 1ps

module gts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  gts_pkg::push_t    push,
    output logic              q_not_full,
    output logic              q_valid,
    output gts_pkg::bundle_t  q_data,
    input  logic              q_pop
);

    localparam int unsigned PTR_W = $clog2(gts_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(gts_pkg::QUEUE_DEPTH + 1);

    gts_pkg::bundle_t   mem_reg [gts_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign q_not_full = (cnt_reg != CNT_W'(gts_pkg::QUEUE_DEPTH));
    assign q_valid    = (cnt_reg != '0);
    assign q_data     = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && q_not_full;
    assign do_pop     = q_pop && q_valid;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.bundle;
        end
    end

endmodule

// ===== hw/rtl/gts_back.sv =====
// back part: hands out the tokens of each bundle one request at a time
`timescale 1ns / 1ps

module gts_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  gts_pkg::bundle_t  q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_kind,
    output logic [15:0]       m_line,
    output logic [15:0]       m_start_res,
    output logic [15:0]       m_length,
    output logic [1:0]        m_error_code,
    output logic              m_last_result
);

    gts_pkg::bundle_t bundle_reg;
    logic             bval_reg, bval_next;
    logic [1:0]       idx_reg, idx_next;
    gts_pkg::token_t  cur;
    logic             is_last;
    logic             out_take;

    assign cur      = bundle_reg.tok[idx_reg];
    assign is_last  = (idx_reg == bundle_reg.count - 2'd1);
    assign out_take = bval_reg && m_ready;

    assign m_valid       = bval_reg;
    assign m_kind        = 4'(cur.kind);
    assign m_line        = cur.line;
    assign m_start_res   = cur.start;
    assign m_length      = cur.length;
    assign m_error_code  = 2'(cur.err);
    assign m_last_result = is_last;

    // load a new bundle when empty or when its last token leaves
    assign q_pop = q_valid && (!bval_reg || (out_take && is_last));

    always_comb begin
        bval_next = bval_reg;
        idx_next  = idx_reg;
        if (q_pop) begin
            bval_next = 1'b1;
            idx_next  = 2'd0;
        end else if (out_take) begin
            if (is_last) begin
                bval_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bval_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            bval_reg <= bval_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            bundle_reg <= q_data;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the grammar token scanner
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned SRC_DEPTH = 65536;
    localparam int unsigned POS_LIMIT = (SRC_DEPTH - 1 < 65535) ? SRC_DEPTH - 1 : 65535;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // one source byte waiting to be sent
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic [3:0] gap;
        logic       drain;
    } src_byte_t;

    // one expected token
    typedef struct packed {
        gts_pkg::token_t tok;
        logic            last;
    } expected_tok_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = '0;
    logic        s_end_of_source = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_kind;
    logic [15:0] m_line;
    logic [15:0] m_start_res;
    logic [15:0] m_length;
    logic [1:0]  m_error_code;
    logic        m_last_result;

    src_byte_t     source_bytes[$];
    expected_tok_t expected_tokens[$];
    int unsigned   bytes_queued = 0;
    int unsigned   bytes_taken = 0;
    int unsigned   gap_cnt = 0;
    int unsigned   rx_wait = 0;
    int unsigned   cycle_count = 0;
    bit            sender_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            failed = 1'b0;

    // scanner state as predicted
    gts_pkg::mode_t scan_state;
    int unsigned    line_cnt;
    int unsigned    pos;
    int unsigned    tok_begin;
    logic [15:0]    first_line_reg;
    expected_tok_t  byte_toks[gts_pkg::MAX_TOKENS];
    int unsigned    byte_tok_n;

    grammar_token_scanner #(
        .SOURCE_DEPTH(SRC_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_end_of_source(s_end_of_source),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_line         (m_line),
        .m_start_res    (m_start_res),
        .m_length       (m_length),
        .m_error_code   (m_error_code),
        .m_last_result  (m_last_result)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_letter(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic void add_token(gts_pkg::kind_t k, int unsigned st, int unsigned len,
                                      gts_pkg::err_t e);
        expected_tok_t t;
        if (byte_tok_n < gts_pkg::MAX_TOKENS) begin
            t.tok.kind = k;
            t.tok.line = line_cnt[15:0];
            t.tok.start = st[15:0];
            t.tok.length = len[15:0];
            t.tok.err = e;
            t.last = 1'b0;
            byte_toks[byte_tok_n] = t;
            byte_tok_n++;
        end
    endfunction

    function automatic void bump_line();
        if (line_cnt < 65535) begin
            line_cnt++;
        end
    endfunction

    // a byte seen with no token in progress
    function automatic void scan_fresh(logic [7:0] c);
        case (c)
            gts_pkg::CH_DASH: scan_state = gts_pkg::MODE_DASH;
            gts_pkg::CH_LPAREN: add_token(gts_pkg::KIND_LPAREN, 0, 0, gts_pkg::ERR_NONE);
            gts_pkg::CH_RPAREN: add_token(gts_pkg::KIND_RPAREN, 0, 0, gts_pkg::ERR_NONE);
            gts_pkg::CH_STAR: add_token(gts_pkg::KIND_STAR, 0, 0, gts_pkg::ERR_NONE);
            gts_pkg::CH_QMARK: add_token(gts_pkg::KIND_OPT, 0, 0, gts_pkg::ERR_NONE);
            gts_pkg::CH_BAR: add_token(gts_pkg::KIND_BAR, 0, 0, gts_pkg::ERR_NONE);
            gts_pkg::CH_SEMI: add_token(gts_pkg::KIND_SEMI, 0, 0, gts_pkg::ERR_NONE);
            gts_pkg::CH_LF: bump_line();
            gts_pkg::CH_CR, gts_pkg::CH_SPACE, gts_pkg::CH_TAB: ;
            gts_pkg::CH_QUOTE: begin
                tok_begin = pos;
                scan_state = gts_pkg::MODE_STR;
            end
            default: begin
                if (is_letter(c)) begin
                    tok_begin = pos;
                    scan_state = gts_pkg::MODE_IDENT;
                end else begin
                    add_token(gts_pkg::KIND_ERR, 0, 0, gts_pkg::ERR_UNEXPECTED);
                end
            end
        endcase
    endfunction

    function automatic void reset_scanner_model();
        first_line_reg = 16'd1;
        scan_state = gts_pkg::MODE_IDLE;
        line_cnt = 1;
        pos = 0;
        tok_begin = 0;
    endfunction

    // predict the tokens of one accepted byte
    function automatic void scan_byte(logic [7:0] c, logic eos);
        int unsigned st;
        int unsigned len;
        byte_tok_n = 0;
        case (scan_state)
            gts_pkg::MODE_DASH: begin
                scan_state = gts_pkg::MODE_IDLE;
                if (c == gts_pkg::CH_GT) begin
                    add_token(gts_pkg::KIND_ARROW, 0, 0, gts_pkg::ERR_NONE);
                end else begin
                    scan_fresh(c);
                end
            end
            gts_pkg::MODE_STR: begin
                if (c == gts_pkg::CH_QUOTE) begin
                    st = (tok_begin + 1 > 65535) ? 65535 : tok_begin + 1;
                    len = (pos > tok_begin + 1) ? pos - tok_begin - 1 : 0;
                    add_token(gts_pkg::KIND_LIT, st, len, gts_pkg::ERR_NONE);
                    scan_state = gts_pkg::MODE_IDLE;
                end else if (c == gts_pkg::CH_LF) begin
                    bump_line();
                end
            end
            gts_pkg::MODE_IDENT: begin
                if (!is_word_char(c)) begin
                    add_token(gts_pkg::KIND_IDENT, tok_begin, pos - tok_begin,
                              gts_pkg::ERR_NONE);
                    scan_state = gts_pkg::MODE_IDLE;
                    scan_fresh(c);
                end
            end
            default: scan_fresh(c);
        endcase

        // end of source closes any open token and restarts
        if (eos) begin
            if (scan_state == gts_pkg::MODE_STR) begin
                add_token(gts_pkg::KIND_ERR, 0, 0, gts_pkg::ERR_OPEN_STR);
            end else if (scan_state == gts_pkg::MODE_IDENT) begin
                len = pos + 1 - tok_begin;
                if (len > 65535) begin
                    len = 65535;
                end
                add_token(gts_pkg::KIND_IDENT, tok_begin, len, gts_pkg::ERR_NONE);
            end
            add_token(gts_pkg::KIND_EOF, 0, 0, gts_pkg::ERR_NONE);
            scan_state = gts_pkg::MODE_IDLE;
            line_cnt = 32'(first_line_reg);
            pos = 0;
            tok_begin = 0;
        end else if (pos < POS_LIMIT) begin
            pos++;
        end

        for (int i = 0; i < byte_tok_n; i++) begin
            if (i == byte_tok_n - 1) begin
                byte_toks[i].last = 1'b1;
            end
            expected_tokens.insert(expected_tokens.size(), byte_toks[i]);
        end
    endfunction

    function automatic void queue_byte(logic [7:0] c, logic eos, logic drain = 1'b0);
        src_byte_t b;
        b.ch = c;
        b.eos = eos;
        b.gap = sender_idle ? 4'($urandom_range(0, 9)) : 4'd0;
        b.drain = drain;
        source_bytes.insert(source_bytes.size(), b);
        bytes_queued++;
    endfunction

    function automatic void queue_text(string s, logic eos_last);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i], eos_last && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        int unsigned r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int unsigned r;
        r = $urandom_range(0, 61);
        if (r < 52) begin
            return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
        end
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return gts_pkg::CH_SPACE;
            1: return gts_pkg::CH_TAB;
            2: return gts_pkg::CH_CR;
            default: return gts_pkg::CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 5))
            0: return gts_pkg::CH_LPAREN;
            1: return gts_pkg::CH_RPAREN;
            2: return gts_pkg::CH_STAR;
            3: return gts_pkg::CH_QMARK;
            4: return gts_pkg::CH_BAR;
            default: return gts_pkg::CH_SEMI;
        endcase
    endfunction

    // string body byte, mostly printable, never a quote
    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        c = ($urandom_range(0, 9) == 0) ? gts_pkg::CH_LF : 8'($urandom_range(32, 126));
        return (c == gts_pkg::CH_QUOTE) ? 8'("x") : c;
    endfunction

    // mostly well-formed lexemes with random content, some noise
    function automatic void add_lexeme();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 19);
        n = $urandom_range(0, 7);
        if (pick < 2) begin
            queue_byte(gts_pkg::CH_DASH, 1'b0);
            queue_byte(gts_pkg::CH_GT, 1'b0);
        end else if (pick < 8) begin
            queue_byte(rand_punct(), 1'b0);
        end else if (pick < 10) begin
            queue_byte(gts_pkg::CH_QUOTE, 1'b0);
            for (int i = 0; i < n; i++) begin
                queue_byte(rand_text_char(), 1'b0);
            end
            queue_byte(gts_pkg::CH_QUOTE, 1'b0);
        end else if (pick < 14) begin
            queue_byte(rand_letter(), 1'b0);
            for (int i = 0; i < n; i++) begin
                queue_byte(rand_word_char(), 1'b0);
            end
        end else if (pick < 16) begin
            queue_byte(rand_blank(), 1'b0);
        end else if (pick == 16) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick == 17) begin
            queue_byte(gts_pkg::CH_DASH, 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick == 18) begin
            queue_byte(gts_pkg::CH_QUOTE, 1'b0);
            queue_byte(rand_text_char(), 1'b0);
        end else begin
            case ($urandom_range(0, 3))
                0: queue_byte(8'($urandom_range(0, 255)), 1'b1);
                1: queue_byte(rand_word_char(), 1'b1);
                2: queue_byte(gts_pkg::CH_DASH, 1'b1);
                default: queue_byte(rand_punct(), 1'b1);
            endcase
        end
    endfunction

    // wait until every request is taken and every token has come back
    task automatic settle();
        do begin
            @(posedge aclk);
        end while (bytes_taken != bytes_queued || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_first_line(logic [15:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        first_line_reg = v;
        if (pos == 0 && scan_state == gts_pkg::MODE_IDLE) begin
            line_cnt = 32'(v);
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // source byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_ready) begin
                scan_byte(s_ch, s_end_of_source);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (source_bytes.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_cnt < source_bytes[0].gap) begin
                    gap_cnt <= gap_cnt + 1;
                    s_valid <= 1'b0;
                end else if (source_bytes[0].drain && expected_tokens.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_ch <= source_bytes[0].ch;
                    s_end_of_source <= source_bytes[0].eos;
                    source_bytes.pop_front();
                    gap_cnt <= 0;
                end
            end
        end
    end

    // token monitor with random back-pressure
    always @(posedge aclk) begin : token_monitor
        expected_tok_t want;
        int unsigned   stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("token with nothing expected: kind %0d", m_kind);
                failed = 1'b1;
            end else begin
                want = expected_tokens.pop_front();
                check_field("kind", 32'(want.tok.kind), 32'(m_kind));
                check_field("line", 32'(want.tok.line), 32'(m_line));
                check_field("start_res", 32'(want.tok.start), 32'(m_start_res));
                check_field("length", 32'(want.tok.length), 32'(m_length));
                check_field("error_code", 32'(want.tok.err), 32'(m_error_code));
                check_field("last_result", 32'(want.last), 32'(m_last_result));
            end
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            rx_wait <= stall;
            m_ready <= (stall == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned chunk_start;
        bit          drain_done;
        drain_done = 1'b0;
        reset_scanner_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every token kind, dropped dash, bad bytes, open string at end
        set_first_line(16'd0);
        queue_text("->()*?|;\"ab\"\tk9; -x\n", 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_text("\r\"q", 1'b1);
        // identifier closed by a token on the final byte, dash at end, alnum at end
        queue_text("ab(", 1'b1);
        queue_text("-", 1'b1);
        queue_text("z7", 1'b1);
        settle();

        // write in mid-source only applies from the next source
        queue_text("rule", 1'b0);
        settle();
        set_first_line(16'hFFFF);
        queue_text(";\n", 1'b1);
        queue_text("\n(", 1'b1);
        settle();

        // line count saturation
        set_first_line(16'hFFFE);
        queue_text("|\n|\n|", 1'b1);
        settle();

        // random lexeme streams, first_line changed between chunks
        for (int chunk = 0; chunk < 5; chunk++) begin
            sender_idle = (chunk != 0);
            rx_idle = (chunk != 1);
            set_first_line((chunk == 3) ? 16'd0 : 16'($urandom_range(0, 65535)));
            chunk_start = bytes_queued;
            while (bytes_queued - chunk_start < 100) begin
                add_lexeme();
                // sender holds off until all tokens are back
                if (chunk == 2 && !drain_done && bytes_queued - chunk_start > 50) begin
                    queue_byte(gts_pkg::CH_SEMI, 1'b0, 1'b1);
                    drain_done = 1'b1;
                end
            end
            settle();
        end

        if (failed) begin
            $display("== FAIL ==");
        end else begin
            $display("== PASS ==");
        end
        $finish;
    end

endmodule
